/* rtl/tile_override_table_unit_macros.svh */
// Assertion macros used by the tile override table engine RTL.
`ifndef TILE_OVERRIDE_TABLE_UNIT_MACROS_SVH
`define TILE_OVERRIDE_TABLE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TOT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TOT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tot_pkg.sv */
// Types and constants shared by the tile override table modules.
package tot_pkg;

  localparam int TABLE_ENTRIES   = 256;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W           = 14;
  localparam int VAL_W           = 14;
  localparam int IN_VALUE_W      = 16;
  localparam int POS_W           = 12;
  localparam int LAYER_W         = 2;
  localparam int RES_W           = 18;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 32;
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [IN_VALUE_W-1:0] VALUE_LIMIT = 16'h4000;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [KEY_W-1:0]      key;
    logic [IN_VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

/* rtl/tot_front.sv */
// Input stage: holds the insert-disable register and turns words into table commands.
module tot_front
  import tot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic                  insert_disable;
  mode_t                 mode;
  logic [IN_VALUE_W-1:0] tile_value;
  logic [POS_W-1:0]      tile_position;
  logic [LAYER_W-1:0]    layer;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_disable <= 1'b0;
    end else if (cfg_we) begin
      insert_disable <= cfg_wdata;
    end
  end

  assign mode          = mode_t'(s_tdata[1:0]);
  assign tile_value    = s_tdata[17:2];
  assign tile_position = s_tdata[29:18];
  assign layer         = s_tdata[31:30];

  assign s_tready  = cmd_ready;
  assign cmd_valid = s_tvalid;

  // An insert that can never be stored is passed on as a no-op; the full check
  // needs the live count and is made by the table engine.
  always_comb begin
    cmd.key   = {layer, tile_position};
    cmd.value = tile_value;
    unique case (mode)
      MODE_INSERT: begin
        if ((tile_value < VALUE_LIMIT) && !insert_disable) begin
          cmd.op = CMD_INSERT;
        end else begin
          cmd.op = CMD_NOP;
        end
      end
      MODE_DELETE: cmd.op = CMD_DELETE;
      MODE_LOOKUP: cmd.op = CMD_LOOKUP;
      default:     cmd.op = CMD_NOP;
    endcase
  end

endmodule

/* rtl/tot_cmd_fifo.sv */
// Short command queue between the input stage and the table engine.
module tot_cmd_fifo
  import tot_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t              slots [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != QCNT_W'(CMD_QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tot_back.sv */
// Table engine: entry memory, linear key scan, swap-remove and the output register.
`include "tile_override_table_unit_macros.svh"

module tot_back
  import tot_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  cmp_vld;
  logic [IDX_W-1:0]      slot;
  cmd_op_t               cur_op;
  logic [KEY_W-1:0]      cur_key;
  logic [IN_VALUE_W-1:0] cur_value;
  logic                  res_acc;
  logic [RES_W-1:0]      res_val;
  logic                  out_acc;
  logic [RES_W-1:0]      out_val;
  logic [CNT_W-1:0]      out_cnt;

  entry_t                mem [TABLE_ENTRIES];
  entry_t                rdata;
  entry_t                wdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      waddr;
  logic [IDX_W-1:0]      raddr;
  logic                  hit;
  logic                  not_full;
  logic                  take;
  logic                  out_load;

  assign cmd_ready = (state == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign not_full  = (count < CNT_W'(TABLE_ENTRIES));
  assign cnt_m1    = count - CNT_W'(1);
  assign hit       = (state == ST_SCAN) && cmp_vld && (rdata.key == cur_key);
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = count[IDX_W-1:0];
    raddr  = rd_idx[IDX_W-1:0];
    wdata  = '{key: cmd.key, value: cmd.value[VAL_W-1:0]};
    unique case (state)
      ST_IDLE: begin
        mem_we = take && (cmd.op == CMD_INSERT) && not_full;
      end
      ST_SCAN: begin
        mem_re = !hit && (rd_idx < count);
      end
      ST_DEL_RD: begin
        mem_re = 1'b1;
        raddr  = cnt_m1[IDX_W-1:0];
      end
      ST_DEL_WR: begin
        mem_we = 1'b1;
        waddr  = slot;
        wdata  = rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      cmp_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cmp_vld <= 1'b0;
          rd_idx  <= '0;
          if (take) begin
            cur_op    <= cmd.op;
            cur_key   <= cmd.key;
            cur_value <= cmd.value;
            res_acc   <= 1'b0;
            res_val   <= '0;
            case (cmd.op)
              CMD_INSERT: begin
                if (not_full) begin
                  count   <= count + CNT_W'(1);
                  res_acc <= 1'b1;
                end
                state <= ST_DONE;
              end
              CMD_DELETE, CMD_LOOKUP: begin
                if (count == '0) begin
                  if (cmd.op == CMD_LOOKUP) begin
                    res_val <= {cmd.value, 2'b00};
                  end
                  state <= ST_DONE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          cmp_vld <= mem_re;
          cmp_idx <= rd_idx[IDX_W-1:0];
          if (mem_re) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (hit) begin
            slot <= cmp_idx;
            if (cur_op == CMD_DELETE) begin
              state <= ST_DEL_RD;
            end else begin
              res_acc <= 1'b1;
              res_val <= {2'b00, rdata.value, 2'b00};
              state   <= ST_DONE;
            end
          end else if (rd_idx == count) begin
            if (cur_op == CMD_LOOKUP) begin
              res_val <= {cur_value, 2'b00};
            end
            state <= ST_DONE;
          end
        end
        ST_DEL_RD: begin
          state <= ST_DEL_WR;
        end
        ST_DEL_WR: begin
          count   <= cnt_m1;
          res_acc <= 1'b1;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            out_acc  <= res_acc;
            out_val  <= res_val;
            out_cnt  <= count;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - 1 - RES_W - CNT_W){1'b0}}, out_cnt, out_val, out_acc};

  `TOT_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(TABLE_ENTRIES), "count beyond table size")
  `TOT_ASSERT_SAME(a_scan_in_range, (state == ST_SCAN) && mem_re, rd_idx < count, "scan past count")
  `TOT_ASSERT_SAME(a_swap_slot, state == ST_DEL_WR, {1'b0, slot} < count, "swap target past count")
  `TOT_ASSERT_NEXT(a_result_shown, out_load, m_tvalid && (state == ST_IDLE), "result not presented")

endmodule

/* rtl/tile_override_table_unit.sv */
// An insert or ignored word goes through the queue and the engine, which loads its result
// into the output register. A lookup or delete on a non-empty table scans one entry per cycle
// up to a hit or the count; a delete that hits then moves the last entry into the freed slot.
// The engine takes a new word only once the last result is in the output register; a scan uses the
// single read port of the entry memory. Synchronous reset empties the table (count zero) and the
// queue and clears insert_disable; entry contents stay undefined, and no clearing pass is run.
module tile_override_table_unit
  import tot_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: insert_disable, written whenever cfg_we is high.
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  // Input words.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // mode[1:0], tile_value[17:2], tile_position[29:18], layer[31:30]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Result words.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accepted[0], result_value[18:1], entry_count[27:19], zero fill[31:28]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // The front stage decodes each word into a command as it is accepted; the
  // queue lets new words come in while the engine is still scanning.
  logic cf_valid;
  logic cf_ready;
  cmd_t cf_cmd;
  logic cb_valid;
  logic cb_ready;
  cmd_t cb_cmd;

  tot_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (cf_valid),
    .cmd_ready (cf_ready),
    .cmd       (cf_cmd)
  );

  tot_cmd_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cf_valid),
    .push_ready (cf_ready),
    .push_cmd   (cf_cmd),
    .pop_valid  (cb_valid),
    .pop_ready  (cb_ready),
    .pop_cmd    (cb_cmd)
  );

  // The engine holds the entry memory and answers each command in order; its
  // output register lets it move on while a result waits to be taken.
  tot_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cb_valid),
    .cmd_ready (cb_ready),
    .cmd       (cb_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* tb/sv/tile_override_table_unit_tb.sv */
// Self-checking testbench for the tile override table unit, with its own table predictor.
module tile_override_table_unit_tb;
  import tot_pkg::*;

  // The slowest correct word is a full-table scan plus a swap-remove, and the receiver may
  // stall on top of that. The watchdog allows several times that before it gives up on a
  // silent bus.
  localparam int IDLE_LIMIT   = 3000;
  // Extra cycles granted after the last result, well beyond the longest scan.
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 44;
  localparam int POOL_KEYS    = 16;
  localparam int SHOW_LIMIT   = 10;

  // Input word as laid out on s_tdata; the first member sits in the top bits.
  typedef struct packed {
    logic [LAYER_W-1:0]    layer;
    logic [POS_W-1:0]      pos;
    logic [IN_VALUE_W-1:0] value;
    mode_t                 mode;
  } table_op_t;

  // Result word as laid out on m_tdata.
  typedef struct packed {
    logic [OUT_TDATA_W-CNT_W-RES_W-2:0] fill;
    logic [CNT_W-1:0]                   count;
    logic [RES_W-1:0]                   value;
    logic                               hit;
  } table_reply_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic                   cfg_wdata = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  tile_override_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. It advances once for every word the block takes,
  // in the order the block takes them, so it always matches the state that the
  // block will see when it works on that word.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] tbl_key [TABLE_ENTRIES];
  logic [VAL_W-1:0] tbl_val [TABLE_ENTRIES];
  int unsigned      tbl_count  = 0;
  bit               insert_off = 1'b0;

  // Figures for the closing summary.
  int unsigned mode_tally [4];
  int unsigned hit_tally  = 0;
  int unsigned peak_count = 0;

  // Works out the answer to one word and applies its effect to the shadow table.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t     r;
    logic [KEY_W-1:0] key;
    int               slot;
    int               i;
    r    = '0;
    key  = {op.layer, op.pos};
    slot = -1;
    // Delete and lookup act on the first match in slot order, below the count only.
    for (i = 0; i < tbl_count; i++) begin
      if (slot < 0 && tbl_key[i] == key) slot = i;
    end
    case (op.mode)
      MODE_INSERT: begin
        // No duplicate check: a second entry with the same key is simply appended.
        if (op.value < VALUE_LIMIT && !insert_off && tbl_count < TABLE_ENTRIES) begin
          tbl_key[tbl_count] = key;
          tbl_val[tbl_count] = op.value[VAL_W-1:0];
          tbl_count++;
          r.hit = 1'b1;
        end
      end
      MODE_DELETE: begin
        // Swap-remove: the last entry moves into the freed slot.
        if (slot >= 0) begin
          tbl_count--;
          tbl_key[slot] = tbl_key[tbl_count];
          tbl_val[slot] = tbl_val[tbl_count];
          r.hit = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        if (slot >= 0) begin
          r.value = {2'b00, tbl_val[slot], 2'b00};
          r.hit   = 1'b1;
        end else begin
          r.value = {op.value, 2'b00};
        end
      end
      default: begin
        // The unused mode changes nothing; accepted and value come back as zero.
      end
    endcase
    r.count = tbl_count[CNT_W-1:0];
    mode_tally[op.mode]++;
    if (r.hit) hit_tally++;
    if (tbl_count > peak_count) peak_count = tbl_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: words wait in op_backlog until the driver puts them on the bus. It
  // sends in bursts of random length, separated by gaps of random length; a
  // gap of zero lets two bursts run together with no idling at all.
  // ---------------------------------------------------------------------------
  table_op_t    op_backlog [$];
  table_reply_t replies_due [$];
  int unsigned  ops_queued = 0;
  int unsigned  ops_taken  = 0;
  int           burst_left = 0;
  int           gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || op_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        s_tdata  <= op_backlog.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(20, 40);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // Every word taken by the block yields exactly one expected result.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      replies_due.push_back(apply_table_op(table_op_t'(s_tdata)));
      ops_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: m_tready follows one of four styles, each picked at random, so
  // that the output sees varied stalls: always ready, a coin toss, ready a
  // quarter of the time, and ready only an eighth of the time with long
  // stalls between.
  // ---------------------------------------------------------------------------
  int unsigned ready_tick  = 0;
  int unsigned ready_style = 0;

  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 97 == 0) ready_style = $urandom_range(0, 3);
    case (ready_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (ready_tick[1:0] == 2'd0);
      default: m_tready <= (ready_tick[4:2] == 3'd0);
    endcase
  end

  // Each result word is checked field by field against the oldest expectation.
  int unsigned mismatches     = 0;
  int unsigned replies_seen   = 0;

  always @(posedge clk) begin : check_replies
    table_reply_t got;
    table_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = table_reply_t'(m_tdata);
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result word %h arrived with nothing outstanding", m_tdata);
      end else begin
        want = replies_due.pop_front();
        if (got.hit !== want.hit || got.value !== want.value || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result %0d: expected accepted %0d value %h count %0d, got %0d %h %0d",
                     replies_seen, want.hit, want.value, want.count,
                     got.hit, got.value, got.count);
        end
      end
      replies_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Ending the run. The watchdog counts cycles in which no word moves on
  // either side; a correct block is never silent for anything like the limit.
  // ---------------------------------------------------------------------------
  task automatic end_run(bit ok);
    if (ok) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, replies_due.size());
      end_run(1'b0);
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Most keys come from a small pool so that lookups and deletes
  // find entries, duplicates build up, and swap-removes happen often.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  // Returns once every queued word has been taken and answered, plus a margin.
  task automatic wait_idle();
    while (ops_taken != ops_queued || replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // The register is only written while the block has nothing in flight.
  task automatic set_insert_disable(bit v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    insert_off = v;
  endtask

  task automatic push_op(mode_t m, logic [KEY_W-1:0] key, logic [IN_VALUE_W-1:0] v);
    table_op_t op;
    op.mode  = m;
    op.value = v;
    op.layer = key[KEY_W-1:POS_W];
    op.pos   = key[POS_W-1:0];
    op_backlog.push_back(op);
    ops_queued++;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  function automatic logic [IN_VALUE_W-1:0] rand_value();
    return IN_VALUE_W'($urandom_range(0, (1 << IN_VALUE_W) - 1));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_KEYS - 1)];
    return rand_key();
  endfunction

  // Mostly storable values, with a share that is too large to store.
  function automatic logic [IN_VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return {IN_VALUE_W{1'b1}};
      1:       return VALUE_LIMIT;
      2, 3:    return IN_VALUE_W'($urandom_range(VALUE_LIMIT, (1 << IN_VALUE_W) - 1));
      default: return IN_VALUE_W'($urandom_range(0, VALUE_LIMIT - 1));
    endcase
  endfunction

  // A random mix with the given percentages of inserts and deletes; lookups
  // fill most of the rest and a few words use the unused mode.
  task automatic push_random(int n, int ins_pct, int del_pct);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        push_op(MODE_INSERT, pick_key(), pick_value());
      else if (roll < ins_pct + del_pct)
        push_op(MODE_DELETE, pick_key(), rand_value());
      else if (roll < 96)
        push_op(MODE_LOOKUP, pick_key(), rand_value());
      else
        push_op(MODE_UNUSED, rand_key(), rand_value());
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_KEYS; k++) key_pool[k] = rand_key();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_insert_disable(1'b0);

    // Directed opening: an empty table, the field extremes, oversized values,
    // duplicate keys, deletes that move the last entry, absent keys and the
    // unused mode.
    push_op(MODE_LOOKUP, 14'h0000, 16'h0000);   // empty table: default comes back
    push_op(MODE_DELETE, 14'h0000, 16'h0000);   // empty table: nothing to remove
    push_op(MODE_INSERT, 14'h0000, 16'h0000);
    push_op(MODE_INSERT, 14'h3fff, 16'h3fff);
    push_op(MODE_INSERT, 14'h0123, VALUE_LIMIT); // just too large
    push_op(MODE_INSERT, 14'h0123, 16'hffff);
    push_op(MODE_INSERT, 14'h0000, 16'h1555);   // duplicate key
    push_op(MODE_LOOKUP, 14'h0000, 16'hffff);   // first match wins
    push_op(MODE_LOOKUP, 14'h3fff, 16'hffff);
    push_op(MODE_LOOKUP, 14'h2aaa, 16'hffff);   // miss with the widest default
    push_op(MODE_DELETE, 14'h0000, 16'hffff);   // last entry moves into slot zero
    push_op(MODE_LOOKUP, 14'h0000, 16'h0000);
    push_op(MODE_DELETE, 14'h1234, 16'h0000);   // absent key
    push_op(MODE_UNUSED, 14'h3fff, 16'hffff);
    push_op(MODE_UNUSED, 14'h0000, 16'h0000);
    push_op(MODE_INSERT, 14'h1555, 16'h2aaa);
    push_op(MODE_INSERT, 14'h2aaa, 16'h1555);
    push_op(MODE_DELETE, 14'h3fff, 16'h0000);   // from the middle
    push_op(MODE_LOOKUP, 14'h2aaa, 16'h0000);
    push_op(MODE_DELETE, 14'h2aaa, 16'h0000);   // now in slot one; the last entry moves in
    set_insert_disable(1'b1);
    push_op(MODE_INSERT, 14'h0777, 16'h0001);   // refused while disabled
    push_op(MODE_LOOKUP, 14'h1555, 16'h0000);
    set_insert_disable(1'b0);
    push_op(MODE_INSERT, 14'h0777, 16'h0001);

    // Random mix; the sender holds off half-way until every answer is back.
    push_random(150, 45, 25);
    wait_idle();
    push_random(150, 40, 30);

    // Fill the table to the brim, then work on it while it is full.
    wait_idle();
    repeat (TABLE_ENTRIES - tbl_count)
      push_op(MODE_INSERT, pick_key(), IN_VALUE_W'($urandom_range(0, VALUE_LIMIT - 1)));
    push_random(40, 50, 20);

    // With inserts disabled the table can only shrink.
    set_insert_disable(1'b1);
    push_random(80, 40, 40);
    set_insert_disable(1'b0);
    push_random(250, 40, 30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      mismatches += replies_due.size();
      $display("%0d results never arrived", replies_due.size());
    end

    $display("summary: %0d words (%0d insert, %0d delete, %0d lookup, %0d unused), %0d hits",
             ops_taken, mode_tally[MODE_INSERT], mode_tally[MODE_DELETE],
             mode_tally[MODE_LOOKUP], mode_tally[MODE_UNUSED], hit_tally);
    $display("summary: table peaked at %0d of %0d, inserts toggled, %0d mismatches",
             peak_count, TABLE_ENTRIES, mismatches);
    end_run(mismatches == 0);
  end

endmodule
